/* rtl/core/quadratic_bezier_winding_test_assert.svh */
// Assertion macros used by the block's top module.
`ifndef QUADRATIC_BEZIER_WINDING_TEST_ASSERT_SVH
`define QUADRATIC_BEZIER_WINDING_TEST_ASSERT_SVH

// Concurrent check on the block clock, muted during reset.
`define QBW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also active while reset is held.
`define QBW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/qbw_pkg.sv */
package qbw_pkg;
    localparam int unsigned CoordW   = 32;
    localparam int unsigned ExtFrac  = 24;
    localparam int unsigned WideW    = 58;
    localparam int unsigned Steps    = 40;
    localparam int unsigned CfgIdxW  = 3;

    localparam logic [CfgIdxW-1:0] RegStartX   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegStartY   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegControlX = 3'd2;
    localparam logic [CfgIdxW-1:0] RegControlY = 3'd3;
    localparam logic [CfgIdxW-1:0] RegEndX     = 3'd4;
    localparam logic [CfgIdxW-1:0] RegEndY     = 3'd5;

    typedef logic signed [WideW-1:0] t_wide;

    // Curve segment carried from cell to cell.
    typedef struct packed {
        logic              vld;
        t_wide             x0, x1, x2;
        t_wide             y0, y1, y2;
        t_wide             ty;
        t_wide             px;
        logic signed [1:0] dir;
        logic              bisect;
        logic signed [1:0] early;
    } t_seg;

    function automatic t_wide half_floor(t_wide a, t_wide b);
        logic signed [WideW:0] s;
        s = {a[WideW-1], a} + {b[WideW-1], b};
        return s[WideW:1];
    endfunction
endpackage

/* rtl/core/qbw_cell.sv */
module qbw_cell
    import qbw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_seg i_seg,
    output t_seg o_seg
);
    t_seg  r_seg, n_seg;
    t_wide ax, bx, ay, by, mx, my;
    logic  go_left;

    always_comb begin
        ax = half_floor(i_seg.x0, i_seg.x1);
        bx = half_floor(i_seg.x1, i_seg.x2);
        ay = half_floor(i_seg.y0, i_seg.y1);
        by = half_floor(i_seg.y1, i_seg.y2);
        mx = half_floor(ax, bx);
        my = half_floor(ay, by);
        go_left = (i_seg.dir > 0) ? (i_seg.ty < my) : (i_seg.ty > my);
        n_seg = i_seg;
        if (go_left) begin
            n_seg.x1 = ax; n_seg.x2 = mx;
            n_seg.y1 = ay; n_seg.y2 = my;
        end else begin
            n_seg.x0 = mx; n_seg.x1 = bx;
            n_seg.y0 = my; n_seg.y1 = by;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.vld <= 1'b0;
        end else if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;
endmodule

/* rtl/core/quadratic_bezier_winding_test.sv */
// Winding contribution of one quadratic Bezier segment for a rightward ray.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
// writes the six control point coordinates: start x/y, control x/y, end x/y.
// Write only while no sample is in flight. Unknown indexes are dropped.
// Sample stream: s_axis tdata = {sample_y, sample_x}; result on m_axis
// tdata = winding (2-bit signed, zero padded to a byte).
// One sample per cycle sustained while the receiver takes results. One entry
// stage does the box tests, forty bisection cells each halve the curve,
// and a final midpoint and compare stage is also the output register.
// The whole pipeline advances when the output register is empty or being
// taken, so a stalled receiver holds every stage and deasserts tready.
// Reset zeroes the six coordinate registers and empties the pipeline.
module quadratic_bezier_winding_test
    import qbw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // sample_x [31:0], sample_y [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // winding [1:0], zeros above
);
    logic signed [CoordW-1:0] r_sx, r_sy, r_cx, r_cy, r_ex, r_ey;
    logic signed [CoordW-1:0] px, py, min_x, max_x, min_y, max_y;
    logic signed [1:0]        dir;
    logic                     adv;
    t_seg                     n_in, r_in;
    t_seg                     chain [Steps+1];
    logic                     r_ovld;
    logic signed [1:0]        r_win, n_win;
    t_seg                     last;
    t_wide                    xm;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0; r_cx <= '0; r_cy <= '0; r_ex <= '0; r_ey <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegStartX:   r_sx <= i_cfg_data;
                RegStartY:   r_sy <= i_cfg_data;
                RegControlX: r_cx <= i_cfg_data;
                RegControlY: r_cy <= i_cfg_data;
                RegEndX:     r_ex <= i_cfg_data;
                RegEndY:     r_ey <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign adv = !r_ovld || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb begin
        px = s_axis_tdata[31:0];
        py = s_axis_tdata[63:32];
        min_x = (r_sx < r_ex) ? r_sx : r_ex;
        max_x = (r_sx < r_ex) ? r_ex : r_sx;
        min_y = (r_sy < r_ey) ? r_sy : r_ey;
        max_y = (r_sy < r_ey) ? r_ey : r_sy;
        dir = (r_ey > r_sy) ? 2'sd1 : ((r_ey < r_sy) ? -2'sd1 : 2'sd0);
        n_in.vld = s_axis_tvalid;
        // sign-extend the widened coordinates to the working width
        n_in.x0 = t_wide'($signed({r_sx, {ExtFrac{1'b0}}}));
        n_in.x1 = t_wide'($signed({r_cx, {ExtFrac{1'b0}}}));
        n_in.x2 = t_wide'($signed({r_ex, {ExtFrac{1'b0}}}));
        n_in.y0 = t_wide'($signed({r_sy, {ExtFrac{1'b0}}}));
        n_in.y1 = t_wide'($signed({r_cy, {ExtFrac{1'b0}}}));
        n_in.y2 = t_wide'($signed({r_ey, {ExtFrac{1'b0}}}));
        n_in.ty = t_wide'($signed({py, {ExtFrac{1'b0}}}));
        n_in.px = t_wide'($signed({px, {ExtFrac{1'b0}}}));
        n_in.dir = dir;
        n_in.bisect = 1'b0;
        n_in.early = 2'sd0;
        if (py >= max_y || py < min_y) n_in.early = 2'sd0;
        else if (px <= min_x)          n_in.early = dir;
        else if (px > max_x)           n_in.early = 2'sd0;
        else                           n_in.bisect = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else if (adv) begin
            r_in <= n_in;
        end
    end

    assign chain[0] = r_in;
    for (genvar g = 0; g < Steps; g++) begin : g_cell
        qbw_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_seg  (chain[g]),
            .o_seg  (chain[g+1])
        );
    end

    always_comb begin
        last = chain[Steps];
        xm = half_floor(half_floor(last.x0, last.x1), half_floor(last.x1, last.x2));
        if (last.bisect) n_win = (last.px <= xm) ? last.dir : 2'sd0;
        else             n_win = last.early;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_ovld <= last.vld;
            r_win <= n_win;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = {6'd0, r_win};

`include "quadratic_bezier_winding_test_assert.svh"
    `QBW_ASSERT(a_stall_hold, i_clk, i_rst_n, r_ovld && !m_axis_tready |=> r_ovld && $stable(r_win), "result changed under stall")
    `QBW_ASSERT(a_ready_tie, i_clk, i_rst_n, s_axis_tready == (!r_ovld || m_axis_tready), "input ready not tied to output stage")
    `QBW_ASSERT(a_zero_dir, i_clk, i_rst_n, m_axis_tvalid && (r_sy == r_ey) |-> r_win == 2'sd0, "flat curve gave nonzero winding")
endmodule

/* tb/sv/quadratic_bezier_winding_test_test.sv */
module quadratic_bezier_winding_test_test;
    import qbw_pkg::*;

    localparam int NumRandom = 600;
    localparam int DrainCycles = 60;
    localparam longint CycleLimit = 400000;

    typedef logic signed [63:0] t_q;

    class winding_scoreboard;
        logic signed [31:0] pts [6];
        logic signed [1:0] pending_winding [$];
        int errors;

        function new();
            foreach (pts[i]) pts[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            if (idx <= RegEndY) pts[idx] = val;
        endfunction

        function t_q avg_floor(t_q a, t_q b);
            t_q s;
            s = a + b;
            return s >>> 1;
        endfunction

        function t_q widen(logic signed [31:0] v);
            return t_q'(v) <<< ExtFrac;
        endfunction

        function logic signed [1:0] crossing(logic signed [31:0] px, logic signed [31:0] py);
            logic signed [31:0] min_x, max_x, min_y, max_y;
            logic signed [1:0] dir;
            t_q x0, x1, x2, y0, y1, y2, ty, ax, bx, ay, by, mx, my, xm;
            logic go_left;
            min_x = pts[RegStartX] < pts[RegEndX] ? pts[RegStartX] : pts[RegEndX];
            max_x = pts[RegStartX] < pts[RegEndX] ? pts[RegEndX] : pts[RegStartX];
            min_y = pts[RegStartY] < pts[RegEndY] ? pts[RegStartY] : pts[RegEndY];
            max_y = pts[RegStartY] < pts[RegEndY] ? pts[RegEndY] : pts[RegStartY];
            dir = pts[RegEndY] > pts[RegStartY] ? 2'sd1 :
                  (pts[RegEndY] < pts[RegStartY] ? -2'sd1 : 2'sd0);
            if (py >= max_y || py < min_y) return 2'sd0;
            if (px <= min_x) return dir;
            if (px > max_x) return 2'sd0;
            x0 = widen(pts[RegStartX]); x1 = widen(pts[RegControlX]);
            x2 = widen(pts[RegEndX]);
            y0 = widen(pts[RegStartY]); y1 = widen(pts[RegControlY]);
            y2 = widen(pts[RegEndY]);
            ty = widen(py);
            for (int k = 0; k < Steps; k++) begin
                ax = avg_floor(x0, x1); bx = avg_floor(x1, x2);
                ay = avg_floor(y0, y1); by = avg_floor(y1, y2);
                mx = avg_floor(ax, bx); my = avg_floor(ay, by);
                go_left = (dir > 0) ? (ty < my) : (ty > my);
                if (go_left) begin
                    x1 = ax; x2 = mx; y1 = ay; y2 = my;
                end else begin
                    x0 = mx; x1 = bx; y0 = my; y1 = by;
                end
            end
            xm = avg_floor(avg_floor(x0, x1), avg_floor(x1, x2));
            return (widen(px) <= xm) ? dir : 2'sd0;
        endfunction

        function void note_sample(logic [63:0] data);
            pending_winding.push_back(crossing(data[31:0], data[63:32]));
        endfunction

        function void check_result(logic [7:0] data);
            logic signed [1:0] want;
            if (pending_winding.size() == 0) begin
                $error("unexpected result tdata=%h", data);
                errors++;
                return;
            end
            want = pending_winding.pop_front();
            if (data[1:0] !== want) begin
                $error("winding expected %0d actual %0d", want, $signed(data[1:0]));
                errors++;
            end
            if (data[7:2] !== 6'd0) begin
                $error("padding expected 0 actual %h", data[7:2]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    winding_scoreboard sb;
    longint cycle_count;
    bit sink_en;

    quadratic_bezier_winding_test u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Receiver: random stalls, long ones now and then.
    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!sink_en) begin
                m_axis_tready <= 1'b1;
            end else if (m_axis_tready && $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                g = gap_len();
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        // wait before returning so the next transfer starts in its own step
        @(negedge i_clk);
    endtask

    task automatic load_curve(logic [31:0] sx, logic [31:0] sy, logic [31:0] cx,
                              logic [31:0] cy, logic [31:0] ex, logic [31:0] ey);
        write_reg(RegStartX, sx);
        write_reg(RegStartY, sy);
        write_reg(RegControlX, cx);
        write_reg(RegControlY, cy);
        write_reg(RegEndX, ex);
        write_reg(RegEndY, ey);
    endtask

    task automatic send_sample(logic [31:0] px, logic [31:0] py, bit allow_gap);
        int g;
        if (allow_gap) begin
            g = gap_len();
            if (g > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_winding.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    // Samples mostly inside the curve's box so the bisection path is exercised.
    task automatic random_phase(int n, bit gaps);
        logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
        logic signed [63:0] span;
        logic [31:0] px, py;
        lo_x = sb.pts[RegStartX] < sb.pts[RegEndX] ? sb.pts[RegStartX] : sb.pts[RegEndX];
        hi_x = sb.pts[RegStartX] < sb.pts[RegEndX] ? sb.pts[RegEndX] : sb.pts[RegStartX];
        lo_y = sb.pts[RegStartY] < sb.pts[RegEndY] ? sb.pts[RegStartY] : sb.pts[RegEndY];
        hi_y = sb.pts[RegStartY] < sb.pts[RegEndY] ? sb.pts[RegEndY] : sb.pts[RegStartY];
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                span = 64'(hi_x) - 64'(lo_x) + 1;
                px = 32'(64'(lo_x) + (({$urandom(), $urandom()} & 64'h7fffffffffffffff) % span));
                span = 64'(hi_y) - 64'(lo_y) + 1;
                py = 32'(64'(lo_y) + (({$urandom(), $urandom()} & 64'h7fffffffffffffff) % span));
            end else begin
                px = rand_word();
                py = rand_word();
            end
            send_sample(px, py, gaps);
        end
        drain();
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        sink_en = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset curve is flat: everything outside the span.
        send_sample(32'h0, 32'h0, 0);
        send_sample(32'h80000000, 32'h7fffffff, 0);
        drain();

        // Rising curve, then probe box edges and extremes.
        load_curve(32'h0000_0000, 32'h0000_0000, 32'h0064_0000, 32'h0032_0000,
                   32'h0000_0000, 32'h0064_0000);
        write_reg(3'd6, 32'hdeadbeef);
        write_reg(3'd7, 32'h12345678);
        send_sample(32'h0, 32'h0, 0);
        send_sample(32'h0, 32'h0064_0000, 0);
        send_sample(32'hffff_ffff, 32'hffff_ffff, 0);
        send_sample(32'h0000_0001, 32'h0032_0000, 0);
        send_sample(32'h0032_0000, 32'h0032_0000, 0);
        send_sample(32'h0033_0000, 32'h0032_0000, 0);
        send_sample(32'h7fffffff, 32'h0010_0000, 0);
        send_sample(32'h80000000, 32'h0010_0000, 0);
        send_sample(32'h7fffffff, 32'h80000000, 0);
        drain();

        // Falling straight line across the full range.
        load_curve(32'h80000000, 32'h7fffffff, 32'h0, 32'h0,
                   32'h7fffffff, 32'h80000000);
        send_sample(32'h0, 32'h0, 0);
        send_sample(32'h0000_0001, 32'hffff_ffff, 0);
        send_sample(32'hffff_ffff, 32'h0000_0001, 0);
        send_sample(32'h7fffffff, 32'h80000000, 0);
        send_sample(32'h80000000, 32'h7ffffffe, 0);
        send_sample(32'h5555_5555, 32'haaaa_aaaa, 0);
        send_sample(32'haaaa_aaaa, 32'h5555_5555, 0);
        drain();

        // Non-monotone curve: control point outside the end points' span.
        load_curve(32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h0010_0000, 32'h0010_0000);
        send_sample(32'h0008_0000, 32'h0008_0000, 0);
        send_sample(32'h0000_8000, 32'h0000_8000, 0);
        drain();

        sink_en = 1'b1;
        for (int ph = 0; ph < 12; ph++) begin
            load_curve(rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word());
            random_phase(NumRandom / 12, ph != 3);
        end

        if (sb.errors == 0 && sb.pending_winding.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (sb.pending_winding.size() != 0)
                $error("%0d results never arrived", sb.pending_winding.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
